### sv/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Shared constants, queue entry types and output formatting functions of the
// character class tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int POS_W       = OFFSET_BITS + 1;
  localparam int OFF_OUT_W   = 16;
  localparam int LEN_OUT_W   = 17;
  localparam int NUM_SYMBOLS = 30;
  localparam int CLASS_W     = 5;
  localparam int DISSOLVE_W  = 3;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 30;

  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_CLASS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_SYMBOL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISSOLVE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ISOLATE      = 3'd3;

  localparam logic [CLASS_W-1:0]     SPLIT_CLASS_RST = 5'd1;
  localparam logic [DISSOLVE_W-1:0]  DISSOLVE_RST    = 3'd7;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [7:0] SYMBOL_TABLE [NUM_SYMBOLS] = '{
    8'h21, 8'h3F, 8'h3A, 8'h3B, 8'h2E, 8'h2C, 8'h40, 8'h23, 8'h24, 8'h25,
    8'h5E, 8'h26, 8'h2A, 8'h2D, 8'h2B, 8'h3D, 8'h2F, 8'h5C, 8'h7E, 8'h7C,
    8'h60, 8'h5F, 8'h3C, 8'h3E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D
  };

  localparam logic [1:0] REC_NONE = 2'd0;
  localparam logic [1:0] REC_ONE  = 2'd1;
  localparam logic [1:0] REC_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0]             cnt;
    logic [OFFSET_BITS-1:0] rec0_off;
    logic [POS_W-1:0]       rec0_len;
    logic [OFFSET_BITS-1:0] rec1_off;
    logic [POS_W-1:0]       rec1_len;
    logic                   flag;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  function automatic logic [OFF_OUT_W-1:0] out_offset(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+OFF_OUT_W-1:0] ext;
    ext = {{OFF_OUT_W{1'b0}}, v};
    return ext[OFF_OUT_W-1:0];
  endfunction

  function automatic logic [LEN_OUT_W-1:0] out_length(input logic [POS_W-1:0] v);
    logic [POS_W+LEN_OUT_W-1:0] ext;
    ext = {{LEN_OUT_W{1'b0}}, v};
    return ext[LEN_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/char_class_tokenizer.sv
// ----------------------------------------------------------------------------
// char_class_tokenizer
// Splits a byte stream into token records (offset, length) by character
// class, with configurable split, drop and isolate behavior.
//
// Input channel in_*: one text byte per request, end_of_text on the last.
// Output channel out_*: token records; end_of_run marks the last record a
// byte caused; offset_overflow is the sticky flag of the current text.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once
// (0 split classes, 1 split symbols, 2 dissolve mask, 3 isolate); write
// only while idle.
// Throughput: one byte per cycle into the classifier while in_ready is high. A
// byte causes zero, one or two records; the output sequencer emits one record
// per cycle while out_ready is high, and the four-entry queue absorbs the rest.
// Path: a record is written into the queue at the edge that accepts its byte
// and into the output register at a later edge; a second record of the same
// byte follows from the pending register once the first is taken.
// Reset: configuration returns to its defaults, position and open token
// clear, the queue and output empty.
// Stall: when out_ready is low the output register holds; the queue fills
// and in_ready drops only when all four entries are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module char_class_tokenizer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [cct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cct_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_text_byte,
  input  wire logic                           in_end_of_text,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cct_pkg::OFF_OUT_W-1:0]       out_token_offset,
  output logic [cct_pkg::LEN_OUT_W-1:0]       out_token_length,
  output logic                                out_end_of_run,
  output logic                                out_offset_overflow
);

  cct_pkg::q_push_t q_push;
  cct_pkg::q_head_t q_head;
  logic             q_full;
  logic             pop;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  cct_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .q_push      (q_push)
  );

  cct_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_head (q_head),
    .full   (q_full)
  );

  cct_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_head              (q_head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_token_offset    (out_token_offset),
    .out_token_length    (out_token_length),
    .out_end_of_run      (out_end_of_run),
    .out_offset_overflow (out_offset_overflow)
  );

endmodule

`default_nettype wire

### sv/cct_front.sv
// ----------------------------------------------------------------------------
// cct_front
// Holds configuration and text position state, classifies each request byte
// and builds the token records it causes into one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [cct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cct_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           accept,
  input  wire logic [7:0]                     text_byte,
  input  wire logic                           end_of_text,
  output cct_pkg::q_push_t                    q_push
);

  localparam logic [cct_pkg::OFFSET_BITS-1:0] TOP = {cct_pkg::OFFSET_BITS{1'b1}};

  logic [cct_pkg::CLASS_W-1:0]     class_mask_r;
  logic [cct_pkg::NUM_SYMBOLS-1:0] sym_mask_r;
  logic [cct_pkg::DISSOLVE_W-1:0]  dissolve_r;
  logic                            isolate_r;

  logic [cct_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [cct_pkg::OFFSET_BITS-1:0] start_r, start_nxt;
  logic                            open_r, open_nxt;
  logic                            ovf_r, ovf_nxt;

  logic                            over, ovf_now;
  logic [cct_pkg::OFFSET_BITS-1:0] idx;
  logic                            nonzero, split, drop, sym_hit, is_space;
  logic                            close_old, iso, open_new, open_after, flush;
  logic [cct_pkg::OFFSET_BITS-1:0] start_after;
  logic [cct_pkg::POS_W-1:0]       old_len, flush_len;

  always_comb begin
    sym_hit = 1'b0;
    for (int k = 0; k < cct_pkg::NUM_SYMBOLS; k++) begin
      if (text_byte == cct_pkg::SYMBOL_TABLE[k] && sym_mask_r[k]) sym_hit = 1'b1;
    end
    is_space = (text_byte == cct_pkg::CH_SP) || (text_byte inside {[8'h09:8'h0D]});
    split = (class_mask_r[0] && is_space)
         || (class_mask_r[1] && text_byte == cct_pkg::CH_LF)
         || (class_mask_r[2] && text_byte == cct_pkg::CH_TAB)
         || (class_mask_r[3] && (text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]}))
         || (class_mask_r[4] && (text_byte inside {[8'h30:8'h39]}))
         || sym_hit;
    drop = (dissolve_r[0] && text_byte == cct_pkg::CH_SP)
        || (dissolve_r[1] && text_byte == cct_pkg::CH_LF)
        || (dissolve_r[2] && text_byte == cct_pkg::CH_TAB);
    nonzero = (text_byte != cct_pkg::CH_NUL);

    over    = pos_r[cct_pkg::OFFSET_BITS];
    ovf_now = ovf_r || over;
    idx     = over ? TOP : pos_r[cct_pkg::OFFSET_BITS-1:0];

    close_old = nonzero && open_r && (split || drop);
    iso       = nonzero && split && isolate_r && !drop;
    open_new  = nonzero && !drop && ((split && !isolate_r) || (!split && !open_r));
    if (!nonzero) begin
      open_after = open_r;
    end else if (split || drop) begin
      open_after = open_new;
    end else begin
      open_after = 1'b1;
    end
    start_after = open_new ? idx : start_r;
    flush       = end_of_text && open_after;

    old_len   = {1'b0, idx} - {1'b0, start_r};
    flush_len = {1'b0, idx} + cct_pkg::POS_W'(1) - {1'b0, start_after};
    if (old_len == '0)   old_len   = cct_pkg::POS_W'(1);
    if (flush_len == '0) flush_len = cct_pkg::POS_W'(1);

    q_push.entry.flag     = ovf_now;
    q_push.entry.rec1_off = iso ? idx : start_after;
    q_push.entry.rec1_len = iso ? cct_pkg::POS_W'(1) : flush_len;
    if (close_old) begin
      q_push.entry.rec0_off = start_r;
      q_push.entry.rec0_len = old_len;
    end else if (iso) begin
      q_push.entry.rec0_off = idx;
      q_push.entry.rec0_len = cct_pkg::POS_W'(1);
    end else begin
      q_push.entry.rec0_off = start_after;
      q_push.entry.rec0_len = flush_len;
    end
    if (close_old && (iso || flush)) begin
      q_push.entry.cnt = cct_pkg::REC_TWO;
    end else if (close_old || iso || flush) begin
      q_push.entry.cnt = cct_pkg::REC_ONE;
    end else begin
      q_push.entry.cnt = cct_pkg::REC_NONE;
    end
    q_push.push = accept && (close_old || iso || flush);

    if (end_of_text) begin
      pos_nxt   = '0;
      start_nxt = '0;
      open_nxt  = 1'b0;
      ovf_nxt   = 1'b0;
    end else begin
      pos_nxt   = over ? pos_r : pos_r + cct_pkg::POS_W'(1);
      start_nxt = start_after;
      open_nxt  = open_after;
      ovf_nxt   = ovf_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_mask_r <= cct_pkg::SPLIT_CLASS_RST;
      sym_mask_r   <= '0;
      dissolve_r   <= cct_pkg::DISSOLVE_RST;
      isolate_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cct_pkg::REG_SPLIT_CLASS:  class_mask_r <= cfg_wdata[cct_pkg::CLASS_W-1:0];
        cct_pkg::REG_SPLIT_SYMBOL: sym_mask_r   <= cfg_wdata[cct_pkg::NUM_SYMBOLS-1:0];
        cct_pkg::REG_DISSOLVE:     dissolve_r   <= cfg_wdata[cct_pkg::DISSOLVE_W-1:0];
        cct_pkg::REG_ISOLATE:      isolate_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      open_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      open_r  <= open_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r[cct_pkg::OFFSET_BITS] |-> (pos_r[cct_pkg::OFFSET_BITS-1:0] == '0))
    else $error("position counter ran past its saturation point");
`endif

endmodule

`default_nettype wire

### sv/cct_queue.sv
// ----------------------------------------------------------------------------
// cct_queue
// Four-entry register queue of record groups between classifier and output
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cct_pkg::q_push_t q_push,
  input  wire logic             pop,
  output cct_pkg::q_head_t      q_head,
  output logic                  full
);

  cct_pkg::q_entry_t            mem_r [cct_pkg::Q_DEPTH];
  logic [cct_pkg::Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [cct_pkg::Q_CNT_W-1:0]  count_r, count_nxt;

  assign full         = (count_r == cct_pkg::Q_CNT_W'(cct_pkg::Q_DEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (q_push.push && !pop) count_nxt = count_r + cct_pkg::Q_CNT_W'(1);
    if (!q_push.push && pop) count_nxt = count_r - cct_pkg::Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (q_push.push) mem_r[wr_ptr_r] <= q_push.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.push) wr_ptr_r <= wr_ptr_r + cct_pkg::Q_PTR_W'(1);
      if (pop)         rd_ptr_r <= rd_ptr_r + cct_pkg::Q_PTR_W'(1);
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push.push && full && !pop))
    else $error("push into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cct_pkg::Q_CNT_W'(cct_pkg::Q_DEPTH))
    else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

### sv/cct_back.sv
// ----------------------------------------------------------------------------
// cct_back
// Output sequencer: pops record groups and presents their records one per
// cycle while out_ready is high through an output register, holding a second record when present.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cct_pkg::q_head_t              q_head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cct_pkg::OFF_OUT_W-1:0]      out_token_offset,
  output logic [cct_pkg::LEN_OUT_W-1:0]      out_token_length,
  output logic                               out_end_of_run,
  output logic                               out_offset_overflow
);

  logic                            out_valid_r;
  logic                            pend_r;
  logic [cct_pkg::OFFSET_BITS-1:0] off_r, pend_off_r;
  logic [cct_pkg::POS_W-1:0]       len_r, pend_len_r;
  logic                            eor_r, ovf_r, pend_ovf_r;
  logic                            adv;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !pend_r && q_head.valid;

  assign out_valid           = out_valid_r;
  assign out_token_offset    = cct_pkg::out_offset(off_r);
  assign out_token_length    = cct_pkg::out_length(len_r);
  assign out_end_of_run      = eor_r;
  assign out_offset_overflow = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (adv) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= q_head.valid;
        pend_r      <= q_head.valid && (q_head.entry.cnt == cct_pkg::REC_TWO);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pend_r) begin
        off_r <= pend_off_r;
        len_r <= pend_len_r;
        eor_r <= 1'b1;
        ovf_r <= pend_ovf_r;
      end else begin
        off_r      <= q_head.entry.rec0_off;
        len_r      <= q_head.entry.rec0_len;
        eor_r      <= (q_head.entry.cnt != cct_pkg::REC_TWO);
        ovf_r      <= q_head.entry.flag;
        pend_off_r <= q_head.entry.rec1_off;
        pend_len_r <= q_head.entry.rec1_len;
        pend_ovf_r <= q_head.entry.flag;
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("second record held without a record on the output");
  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_head.valid)
    else $error("pop from an empty queue");
  a_pend_then_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_ready) |=> (out_valid_r && eor_r))
    else $error("held record not presented as last of its run");
`endif

endmodule

`default_nettype wire
